// ===== design/matrix_multiply_engine_defines.svh =====
// assertion macros for the matrix multiply engine
// used by the top level only, no other dependencies
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mme_pkg.sv =====
// shared types and constants of the matrix multiply engine
// no dependencies
package mme_pkg;

    localparam int IDX_W    = 2;
    localparam int ELEM_W   = 16;
    localparam int ACC_W    = 32;
    localparam int DEF_ROWS  = 4;
    localparam int DEF_INNER = 4;
    localparam int DEF_COLS  = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD_LEFT  = 2'd0,
        FUNC_LOAD_RIGHT = 2'd1,
        FUNC_COMPUTE    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        t_func                     func;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [ELEM_W-1:0]  element;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic signed [ACC_W-1:0]   product_value;
        logic                      last;
    } t_out_item;

endpackage

// ===== design/mme_stream_if.sv =====
// valid/ready channel carrying one item of a given payload type
// payload types come from mme_pkg
interface mme_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mme_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== design/matrix_multiply_engine.sv =====
// Integer matrix multiply engine. Load items write one signed 16-bit element of the left
// (ROWS x INNER) or right (INNER x COLS) matrix; loads outside the matrix and func code 3
// are dropped. A compute item walks every (row, col, inner) triple through one shared
// 16x16 multiplier and a 32-bit wrapping accumulator, one multiply-accumulate per cycle
// while the output is not stalled, and emits ROWS*COLS results in row-major order with
// last set on the final one. A compute item keeps the input not ready until its run has
// drained; a stalled output freezes the whole pipeline. Both matrices sit in small rams
// (mme_ram) and must be loaded before use. Depends on mme_pkg, mme_stream_if, mme_ram.
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine #(
    parameter int ROWS  = mme_pkg::DEF_ROWS,
    parameter int INNER = mme_pkg::DEF_INNER,
    parameter int COLS  = mme_pkg::DEF_COLS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mme_stream_if.sink   i_in,
    mme_stream_if.source o_out
);
    import mme_pkg::*;

    localparam int LD  = ROWS * INNER;
    localparam int RD  = INNER * COLS;
    localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
    localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
    localparam int IW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int JW  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int KW  = (INNER > 1) ? $clog2(INNER) : 1;

    typedef struct packed {
        logic             first;
        logic             k_last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

    t_state r_state, n_state;
    logic [IW-1:0] r_i, n_i;
    logic [JW-1:0] r_j, n_j;
    logic [KW-1:0] r_k, n_k;

    logic      r_a_valid, r_b_valid, r_o_valid;
    t_tag      r_a_tag, r_b_tag, issue_tag;
    t_out_item r_o;
    logic signed [ACC_W-1:0] r_prod, r_acc, sum;
    logic signed [ACC_W-1:0] left_ext, right_ext;
    logic signed [ELEM_W-1:0] left_q, right_q;

    logic stall, advance, issue, in_acc;
    logic k_last, j_last, i_last;
    logic left_wr, right_wr;
    logic [LAW-1:0] left_wr_addr, left_rd_addr;
    logic [RAW-1:0] right_wr_addr, right_rd_addr;
    t_in_item in_item;

    assign in_item = i_in.payload;

    // whole pipeline holds while a finished result waits
    assign stall   = r_o_valid && !o_out.ready;
    assign advance = !stall;
    assign issue   = (r_state == ST_RUN) && advance;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // load path
    always_comb begin
        left_wr  = 1'b0;
        right_wr = 1'b0;
        if (in_acc) begin
            case (in_item.func)
                FUNC_LOAD_LEFT: begin
                    left_wr = ({2'b00, in_item.row_index} < 4'(ROWS))
                           && ({2'b00, in_item.col_index} < 4'(INNER));
                end
                FUNC_LOAD_RIGHT: begin
                    right_wr = ({2'b00, in_item.row_index} < 4'(INNER))
                            && ({2'b00, in_item.col_index} < 4'(COLS));
                end
                default: begin
                    left_wr  = 1'b0;
                    right_wr = 1'b0;
                end
            endcase
        end
    end

    assign left_wr_addr  = LAW'(in_item.row_index) * LAW'(INNER) + LAW'(in_item.col_index);
    assign right_wr_addr = RAW'(in_item.row_index) * RAW'(COLS) + RAW'(in_item.col_index);
    assign left_rd_addr  = LAW'(r_i) * LAW'(INNER) + LAW'(r_k);
    assign right_rd_addr = RAW'(r_k) * RAW'(COLS) + RAW'(r_j);

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(LD)) u_left_ram (
        .i_clk     (i_clk),
        .i_wr_en   (left_wr),
        .i_wr_addr (left_wr_addr),
        .i_wr_data (in_item.element),
        .i_rd_en   (issue),
        .i_rd_addr (left_rd_addr),
        .o_rd_data (left_q)
    );

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(RD)) u_right_ram (
        .i_clk     (i_clk),
        .i_wr_en   (right_wr),
        .i_wr_addr (right_wr_addr),
        .i_wr_data (in_item.element),
        .i_rd_en   (issue),
        .i_rd_addr (right_rd_addr),
        .o_rd_data (right_q)
    );

    assign k_last = (r_k == KW'(INNER - 1));
    assign j_last = (r_j == JW'(COLS - 1));
    assign i_last = (r_i == IW'(ROWS - 1));

    assign issue_tag.first  = (r_k == '0);
    assign issue_tag.k_last = k_last;
    assign issue_tag.row    = IDX_W'(r_i);
    assign issue_tag.col    = IDX_W'(r_j);
    assign issue_tag.last   = i_last && j_last;

    // sequencer: index walk over row, col, inner
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && in_item.func == FUNC_COMPUTE) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (k_last) begin
                        n_k = '0;
                        if (j_last) begin
                            n_j = '0;
                            if (i_last) begin
                                n_state = ST_DRAIN;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_a_valid && !r_b_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // multiply-accumulate datapath
    assign left_ext  = ACC_W'(left_q);
    assign right_ext = ACC_W'(right_q);
    assign sum       = r_b_tag.first ? r_prod : r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance && r_b_valid && r_b_tag.k_last) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (advance) begin
                r_a_valid <= issue;
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_tag <= issue_tag;
            r_b_tag <= r_a_tag;
            r_prod  <= left_ext * right_ext;
            if (r_b_valid) begin
                r_acc <= sum;
                if (r_b_tag.k_last) begin
                    r_o.out_row       <= r_b_tag.row;
                    r_o.out_col       <= r_b_tag.col;
                    r_o.product_value <= sum;
                    r_o.last          <= r_b_tag.last;
                end
            end
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.payload = r_o;

    `MME_ASSERT_NOW(a_ready_pipe_empty, i_clk, i_rst_n, i_in.ready, !r_a_valid && !r_b_valid, "input ready while multiply-accumulate pipeline busy")
    `MME_ASSERT_NEXT(a_sum_lands, i_clk, i_rst_n, advance && r_b_valid && r_b_tag.k_last, r_o_valid, "finished sum not placed in output register")
    `MME_ASSERT_NEXT(a_stall_holds_acc, i_clk, i_rst_n, stall && r_b_valid, $stable(r_acc) && r_b_valid, "accumulator moved during output stall")

endmodule
